@@ sv/hts_pkg.sv @@
package hts_pkg;

  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int ROM_AW = 5;
  localparam int LEN_W  = 4;

  // escape table layout: back+bold run together so the first bold is one run
  localparam logic [ROM_AW-1:0] BACK_BOLD_START = 5'd0;
  localparam logic [LEN_W-1:0]  BACK_BOLD_LEN   = 4'd9;
  localparam logic [ROM_AW-1:0] BOLD_START      = 5'd5;
  localparam logic [LEN_W-1:0]  BOLD_LEN        = 4'd4;
  localparam logic [ROM_AW-1:0] RESET_START     = 5'd9;
  localparam logic [LEN_W-1:0]  RESET_LEN       = 4'd8;
  localparam logic [ROM_AW-1:0] TAB_START       = 5'd17;
  localparam logic [LEN_W-1:0]  TAB_LEN         = 4'd3;

  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NL    = 8'h0A;

  localparam int CAND_P   = 0;
  localparam int CAND_BR  = 1;
  localparam int CAND_B   = 2;
  localparam int CAND_TAB = 3;
  localparam int NCAND    = 4;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } out_item_t;

  typedef struct packed {
    logic              is_lit;
    logic [7:0]        lit_byte;
    logic [ROM_AW-1:0] start;
    logic [LEN_W-1:0]  len;
  } act_t;

  function automatic logic [7:0] esc_byte(input logic [ROM_AW-1:0] idx);
    logic [7:0] b;
    unique case (idx)
      5'd0:    b = 8'h1B;
      5'd1:    b = "[";
      5'd2:    b = "4";
      5'd3:    b = "5";
      5'd4:    b = "m";
      5'd5:    b = 8'h1B;
      5'd6:    b = "[";
      5'd7:    b = "1";
      5'd8:    b = "m";
      5'd9:    b = 8'h1B;
      5'd10:   b = "[";
      5'd11:   b = "2";
      5'd12:   b = "2";
      5'd13:   b = ";";
      5'd14:   b = "4";
      5'd15:   b = "9";
      5'd16:   b = "m";
      5'd17:   b = CH_SPACE;
      5'd18:   b = CH_SPACE;
      5'd19:   b = CH_SPACE;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [LEN_W-1:0] cand_len(input int k);
    logic [LEN_W-1:0] l;
    case (k)
      CAND_P:  l = 4'd1;
      CAND_BR: l = 4'd2;
      CAND_B:  l = 4'd1;
      default: l = 4'd11;
    endcase
    return l;
  endfunction

  function automatic logic [7:0] cand_char(input int k, input logic [LEN_W-1:0] idx);
    logic [7:0] ch;
    ch = 8'h00;
    case (k)
      CAND_P:  ch = "p";
      CAND_BR: ch = (idx == 4'd0) ? 8'("b") : 8'("r");
      CAND_B:  ch = "b";
      default: begin
        case (idx)
          4'd0:    ch = "s";
          4'd1:    ch = "t";
          4'd2:    ch = "y";
          4'd3:    ch = "l";
          4'd4:    ch = "e";
          4'd5:    ch = "=";
          4'd6:    ch = 8'h22;
          4'd7:    ch = "t";
          4'd8:    ch = "a";
          4'd9:    ch = "b";
          4'd10:   ch = 8'h22;
          default: ch = 8'h00;
        endcase
      end
    endcase
    return ch;
  endfunction

endpackage

@@ sv/hts_front.sv @@
module hts_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  hts_pkg::in_item_t in_data,
  input  logic              color_en,
  input  logic              q_ready,
  output logic              q_push,
  output hts_pkg::act_t     q_act
);
  import hts_pkg::*;

  typedef enum logic [4:0] {
    M_TEXT   = 5'b00001,
    M_VAGUE  = 5'b00010,
    M_OPEN   = 5'b00100,
    M_PARAMS = 5'b01000,
    M_CLOSE  = 5'b10000
  } mode_t;

  mode_t            mode_r, mode_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [NCAND-1:0] flags_r, flags_nxt;
  logic             fbp_r, fbp_nxt;
  logic             drop_r, drop_nxt;

  logic             accept;
  logic [7:0]       c, lc;
  logic [NCAND-1:0] take_flags, fresh_flags, hit;
  logic [LEN_W-1:0] take_len;
  logic             is_end;

  assign in_ready = q_ready;
  assign accept   = in_valid && q_ready;
  assign c        = in_data.text_byte;
  assign lc       = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  assign is_end   = (c == CH_SPACE) || (c == CH_GT);
  assign take_len = (len_r == 4'hF) ? len_r : len_r + 4'd1;

  always_comb begin
    for (int k = 0; k < NCAND; k++) begin
      take_flags[k]  = flags_r[k] && len_r < cand_len(k) && cand_char(k, len_r) == lc;
      fresh_flags[k] = cand_char(k, 4'd0) == lc;
      hit[k]         = flags_r[k] && len_r == cand_len(k);
    end
  end

  always_comb begin
    mode_nxt  = mode_r;
    len_nxt   = len_r;
    flags_nxt = flags_r;
    fbp_nxt   = fbp_r;
    drop_nxt  = drop_r;
    q_push    = 1'b0;
    q_act     = '{is_lit: 1'b1, lit_byte: c, start: '0, len: 4'd1};
    unique case (mode_r)
      M_VAGUE: begin
        if (c == CH_SLASH) begin
          mode_nxt  = M_CLOSE;
          len_nxt   = '0;
          flags_nxt = '1;
        end else begin
          mode_nxt  = M_OPEN;
          len_nxt   = 4'd1;
          flags_nxt = fresh_flags;
        end
      end
      M_OPEN: begin
        if (is_end) begin
          if (hit[CAND_P] || hit[CAND_BR]) begin
            q_push         = 1'b1;
            q_act.lit_byte = CH_NL;
          end else if (hit[CAND_B]) begin
            fbp_nxt = 1'b0;
            q_push  = color_en;
            q_act   = fbp_r ? act_t'{1'b0, 8'h00, BACK_BOLD_START, BACK_BOLD_LEN}
                            : act_t'{1'b0, 8'h00, BOLD_START, BOLD_LEN};
          end
          mode_nxt  = (c == CH_SPACE) ? M_PARAMS : M_TEXT;
          len_nxt   = '0;
          flags_nxt = '1;
        end else begin
          len_nxt   = take_len;
          flags_nxt = take_flags;
        end
      end
      M_PARAMS: begin
        if (c == CH_GT) begin
          q_push    = hit[CAND_TAB];
          q_act     = '{1'b0, 8'h00, TAB_START, TAB_LEN};
          mode_nxt  = M_TEXT;
          len_nxt   = '0;
          flags_nxt = '1;
        end else begin
          len_nxt   = take_len;
          flags_nxt = take_flags;
        end
      end
      M_CLOSE: begin
        if (c == CH_GT) begin
          if (hit[CAND_B]) begin
            q_push = color_en;
            q_act  = '{1'b0, 8'h00, RESET_START, RESET_LEN};
          end else if (hit[CAND_P]) begin
            drop_nxt = 1'b1;
          end
          mode_nxt  = M_TEXT;
          len_nxt   = '0;
          flags_nxt = '1;
        end else begin
          len_nxt   = take_len;
          flags_nxt = take_flags;
        end
      end
      default: begin
        mode_nxt = M_TEXT;
        if (!(drop_r && c == CH_SPACE)) begin
          drop_nxt = 1'b0;
          if (c == CH_LT) mode_nxt = M_VAGUE;
          else            q_push   = 1'b1;
        end
      end
    endcase
    if (in_data.end_of_text) begin
      mode_nxt  = M_TEXT;
      len_nxt   = '0;
      flags_nxt = '1;
      fbp_nxt   = 1'b1;
      drop_nxt  = 1'b0;
    end
    if (!accept) q_push = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= M_TEXT;
      len_r   <= '0;
      flags_r <= '1;
      fbp_r   <= 1'b1;
      drop_r  <= 1'b0;
    end else if (accept) begin
      mode_r  <= mode_nxt;
      len_r   <= len_nxt;
      flags_r <= flags_nxt;
      fbp_r   <= fbp_nxt;
      drop_r  <= drop_nxt;
    end
  end

endmodule

@@ sv/hts_queue.sv @@
module hts_queue #(
  parameter int DEPTH = hts_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  hts_pkg::act_t push_act,
  output logic          not_full,
  output logic          head_valid,
  output hts_pkg::act_t head_act,
  input  logic          pop
);
  import hts_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  act_t          mem [DEPTH];
  logic [PW-1:0] wr_r, rd_r;
  logic [CW-1:0] cnt_r;
  logic          do_push, do_pop;

  assign not_full   = cnt_r != CW'(DEPTH);
  assign head_valid = cnt_r != '0;
  assign head_act   = mem[rd_r];
  assign do_push    = push && not_full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_r] <= push_act;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wr_r <= (wr_r == PW'(DEPTH - 1)) ? '0 : wr_r + PW'(1);
      if (do_pop)  rd_r <= (rd_r == PW'(DEPTH - 1)) ? '0 : rd_r + PW'(1);
      if (do_push && !do_pop)      cnt_r <= cnt_r + CW'(1);
      else if (do_pop && !do_push) cnt_r <= cnt_r - CW'(1);
    end
  end

endmodule

@@ sv/hts_back.sv @@
module hts_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               head_valid,
  input  hts_pkg::act_t      head_act,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output hts_pkg::out_item_t out_data
);
  import hts_pkg::*;

  logic [LEN_W-1:0]  off_r;
  logic              ov_r;
  out_item_t         od_r;
  logic              load, is_last;
  logic [ROM_AW-1:0] idx;
  logic [7:0]        b;

  assign load    = head_valid && (!ov_r || out_ready);
  assign idx     = head_act.start + ROM_AW'(off_r);
  assign b       = head_act.is_lit ? head_act.lit_byte : esc_byte(idx);
  assign is_last = head_act.is_lit || (off_r == head_act.len - 4'd1);
  assign pop     = load && is_last;

  assign out_valid = ov_r;
  assign out_data  = od_r;

  always_ff @(posedge clk) begin
    if (load) od_r <= '{out_byte: b, last_of_run: is_last};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r  <= 1'b0;
      off_r <= '0;
    end else begin
      if (load)           ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
      // step through the escape run one byte per beat
      if (load) off_r <= is_last ? '0 : off_r + 4'd1;
    end
  end

endmodule

@@ sv/html_tag_stripper.sv @@
// an accepted input beat is registered in the action queue, then its first
//   result beat in the output register; throughput: one input byte per
//   cycle while the queue has room; escape runs (up to 9 bytes) are held
//   in a 4-deep action queue between the parser and the byte sequencer
// reset: synchronous active-low rst_n clears the parser, queue and output
//   register; color_enable resets to 1
module html_tag_stripper #(
  parameter int QUEUE_DEPTH = hts_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  hts_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output hts_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic               cfg_wdata
);
  import hts_pkg::*;

  logic color_en_r;
  logic q_ready, q_push, q_valid, q_pop;
  act_t q_in, q_head;

  always_ff @(posedge clk) begin
    if (!rst_n)      color_en_r <= 1'b1;
    else if (cfg_we) color_en_r <= cfg_wdata;
  end

  hts_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .color_en (color_en_r),
    .q_ready  (q_ready),
    .q_push   (q_push),
    .q_act    (q_in)
  );

  hts_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_act   (q_in),
    .not_full   (q_ready),
    .head_valid (q_valid),
    .head_act   (q_head),
    .pop        (q_pop)
  );

  hts_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_valid),
    .head_act   (q_head),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  // a run still being emitted keeps its action at the queue head
  a_run_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last_of_run |-> q_valid)
    else $error("escape run lost its queue entry");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !q_valid |-> in_ready)
    else $error("empty queue stalls input");

  a_pop_loads: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> out_valid && out_data.last_of_run)
    else $error("queue pop without final byte");

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
  import hts_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef enum logic [2:0] {PM_TEXT, PM_LT, PM_OPEN, PM_ATTR, PM_CLOSE} parse_t;
  typedef enum logic [1:0] {ROW_PRED, ROW_NONE, ROW_ONE} row_kind_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
    row_kind_t  kind;
    logic [7:0] want_byte;
  } row_t;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;
  logic      cfg_we;
  logic      cfg_wdata;

  html_tag_stripper dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  // shadow of the stripper state
  parse_t     mode;
  logic [3:0] name_len;
  logic [3:0] flags;
  logic       first_bold;
  logic       drop_sp;
  logic       color_en;

  logic [7:0] burst [$];
  out_item_t  due_bytes [$];
  in_item_t   pend [$];
  row_t       dir_rows [28];

  int          n_err = 0;
  int unsigned cycle_cnt = 0;
  bit          calm = 1'b0;
  bit          long_hold_req = 1'b0;
  bit          long_hold_done = 1'b0;
  out_item_t   want;

  function automatic string word_of(input int k);
    case (k)
      CAND_P:  return "p";
      CAND_BR: return "br";
      CAND_B:  return "b";
      default: return "style=\"tab\"";
    endcase
  endfunction

  function automatic void clear_parse();
    mode = PM_TEXT;
    name_len = 4'd0;
    flags = 4'hF;
    first_bold = 1'b1;
    drop_sp = 1'b0;
  endfunction

  function automatic void new_name();
    name_len = 4'd0;
    flags = 4'hF;
  endfunction

  function automatic void take_name(input logic [7:0] c);
    logic [7:0] lc;
    string w;
    lc = (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
    for (int k = 0; k < NCAND; k++) begin
      w = word_of(k);
      if (flags[k] && (int'(name_len) >= w.len() || w[name_len] != lc))
        flags[k] = 1'b0;
    end
    if (name_len != 4'd15)
      name_len = name_len + 4'd1;
  endfunction

  function automatic bit hit(input int k);
    string w;
    w = word_of(k);
    return flags[k] && int'(name_len) == w.len();
  endfunction

  function automatic void add_esc(input string s);
    burst.push_back(8'h1B);
    for (int i = 0; i < s.len(); i++)
      burst.push_back(s[i]);
  endfunction

  // bytes produced by one input beat go to burst
  function automatic void strip_step(input in_item_t it);
    logic [7:0] c;
    c = it.text_byte;
    burst = {};
    case (mode)
      PM_LT: begin
        new_name();
        if (c == CH_SLASH) begin
          mode = PM_CLOSE;
        end else begin
          mode = PM_OPEN;
          take_name(c);
        end
      end
      PM_OPEN: begin
        if (c == CH_SPACE || c == CH_GT) begin
          if (hit(CAND_P) || hit(CAND_BR)) begin
            burst.push_back(CH_NL);
          end else if (hit(CAND_B)) begin
            if (first_bold) begin
              if (color_en)
                add_esc("[45m");
              first_bold = 1'b0;
            end
            if (color_en)
              add_esc("[1m");
          end
          mode = (c == CH_SPACE) ? PM_ATTR : PM_TEXT;
          new_name();
        end else begin
          take_name(c);
        end
      end
      PM_ATTR: begin
        if (c == CH_GT) begin
          if (hit(CAND_TAB))
            repeat (3) burst.push_back(CH_SPACE);
          mode = PM_TEXT;
          new_name();
        end else begin
          take_name(c);
        end
      end
      PM_CLOSE: begin
        if (c == CH_GT) begin
          if (hit(CAND_B)) begin
            if (color_en)
              add_esc("[22;49m");
          end else if (hit(CAND_P)) begin
            drop_sp = 1'b1;
          end
          mode = PM_TEXT;
          new_name();
        end else begin
          take_name(c);
        end
      end
      default: begin
        mode = PM_TEXT;
        if (!(drop_sp && c == CH_SPACE)) begin
          drop_sp = 1'b0;
          if (c == CH_LT)
            mode = PM_LT;
          else
            burst.push_back(c);
        end
      end
    endcase
    if (it.end_of_text)
      clear_parse();
  endfunction

  function automatic void book(input in_item_t it, input row_kind_t kind,
                               input logic [7:0] want_byte);
    out_item_t beat;
    strip_step(it);
    if (kind == ROW_PRED) begin
      foreach (burst[i]) begin
        beat.out_byte = burst[i];
        beat.last_of_run = (i == burst.size() - 1);
        due_bytes.push_back(beat);
      end
    end else if (kind == ROW_ONE) begin
      beat.out_byte = want_byte;
      beat.last_of_run = 1'b1;
      due_bytes.push_back(beat);
    end
  endfunction

  function automatic void put(input logic [7:0] b);
    in_item_t it;
    it.text_byte = b;
    it.end_of_text = 1'b0;
    pend.push_back(it);
  endfunction

  // letters get a random case
  function automatic void put_word(input string s);
    logic [7:0] ch;
    for (int i = 0; i < s.len(); i++) begin
      ch = s[i];
      if (ch >= 8'h61 && ch <= 8'h7A && $urandom_range(0, 1) == 1)
        ch = ch - 8'd32;
      put(ch);
    end
  endfunction

  function automatic string pick_name();
    case ($urandom_range(0, 8))
      0:       return "p";
      1:       return "br";
      2, 3:    return "b";
      4:       return "i";
      5:       return "bold";
      6:       return "style";
      7:       return "pbbbbbbbbbbbbbbbbr";
      default: return "bb";
    endcase
  endfunction

  function automatic string pick_attr();
    case ($urandom_range(0, 6))
      0, 1:    return "style=\"tab\"";
      2:       return "style=\"tab\" ";
      3:       return "style=\"ta\"";
      4:       return "style=\"tabx\"";
      5:       return "style= \"tab\"";
      default: return "x=1";
    endcase
  endfunction

  // one text of random tokens, end_of_text on its last byte
  function automatic void gen_text();
    int ntok;
    int len;
    logic [7:0] ch;
    in_item_t tail;
    pend = {};
    ntok = $urandom_range(1, 6);
    repeat (ntok) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          len = $urandom_range(1, 5);
          repeat (len) begin
            if ($urandom_range(0, 3) == 0)
              ch = 8'($urandom_range(0, 255));
            else
              ch = 8'($urandom_range(32, 126));
            if (ch == CH_LT)
              ch = CH_SPACE;
            put(ch);
          end
        end
        2, 3: begin
          put(CH_LT);
          put_word(pick_name());
          if ($urandom_range(0, 2) == 0) begin
            put(CH_SPACE);
            put_word(pick_attr());
          end
          put(CH_GT);
        end
        4: begin
          put(CH_LT);
          put(CH_SLASH);
          put_word(pick_name());
          put(CH_GT);
        end
        5: begin
          put(CH_LT);
          put(CH_SLASH);
          put_word("p");
          put(CH_GT);
          repeat ($urandom_range(0, 3)) put(CH_SPACE);
          put_word("x");
        end
        6: begin
          put(CH_LT);
          if ($urandom_range(0, 1) == 1)
            put_word("p");
          else
            put_word("br");
          put(CH_SPACE);
          put_word(pick_attr());
          put(CH_GT);
        end
        7: begin
          put(CH_LT);
          put_word("b");
          put(CH_GT);
          put_word("hi");
          put(CH_LT);
          put(CH_SLASH);
          put_word("b");
          put(CH_GT);
        end
        8: begin
          repeat ($urandom_range(1, 3)) put(8'($urandom_range(0, 255)));
        end
        default: begin
          put(CH_LT);
          put($urandom_range(0, 1) ? CH_GT : CH_SPACE);
          put(CH_GT);
        end
      endcase
    end
    // tag left open at the end of the text
    if ($urandom_range(0, 7) == 0) begin
      put(CH_LT);
      put_word("b");
    end
    tail = pend.pop_back();
    tail.end_of_text = 1'b1;
    pend.push_back(tail);
  endfunction

  task automatic offer(input in_item_t it);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_color(input logic v);
    in_valid <= 1'b0;
    while (due_bytes.size() != 0) @(posedge clk);
    // beats that produce nothing may still be in flight
    repeat (8) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    color_en = v;
  endtask

  task automatic run_random(input int n_items);
    int sent;
    sent = 0;
    while (sent < n_items) begin
      gen_text();
      foreach (pend[i]) begin
        offer(pend[i]);
        book(pend[i], ROW_PRED, 8'h00);
      end
      sent += pend.size();
    end
  endtask

  // result side: random stalls, one long hold-off on request
  initial begin
    int gap;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (long_hold_req && !long_hold_done) begin
        out_ready <= 1'b0;
        repeat (80) @(posedge clk);
        long_hold_done = 1'b1;
        out_ready <= 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        gap = $urandom_range(1, 6);
        repeat (gap) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (due_bytes.size() == 0) begin
        $display("%0t: unexpected beat, got byte %h last %b", $time,
                 out_data.out_byte, out_data.last_of_run);
        n_err++;
      end else begin
        want = due_bytes.pop_front();
        if (out_data.out_byte !== want.out_byte ||
            out_data.last_of_run !== want.last_of_run) begin
          $display("%0t: expected byte %h last %b, got byte %h last %b", $time,
                   want.out_byte, want.last_of_run, out_data.out_byte,
                   out_data.last_of_run);
          n_err++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    in_item_t it;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_ready = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = 1'b0;
    color_en  = 1'b1;
    clear_parse();

    dir_rows = '{
      '{8'h41,    1'b0, ROW_ONE,  8'h41},
      '{8'h00,    1'b0, ROW_ONE,  8'h00},
      '{8'hFF,    1'b0, ROW_ONE,  8'hFF},
      '{CH_LT,    1'b0, ROW_NONE, 8'h00},
      '{8'h70,    1'b0, ROW_NONE, 8'h00},
      '{CH_GT,    1'b0, ROW_ONE,  CH_NL},
      // closing p, then the spaces after it vanish
      '{CH_LT,    1'b0, ROW_NONE, 8'h00},
      '{CH_SLASH, 1'b0, ROW_NONE, 8'h00},
      '{8'h50,    1'b0, ROW_NONE, 8'h00},
      '{CH_GT,    1'b0, ROW_NONE, 8'h00},
      '{CH_SPACE, 1'b0, ROW_NONE, 8'h00},
      '{CH_SPACE, 1'b0, ROW_NONE, 8'h00},
      '{8'h71,    1'b0, ROW_ONE,  8'h71},
      // first bold of the text carries the background escape
      '{CH_LT,    1'b0, ROW_NONE, 8'h00},
      '{8'h42,    1'b0, ROW_NONE, 8'h00},
      '{CH_GT,    1'b0, ROW_PRED, 8'h00},
      '{CH_LT,    1'b0, ROW_NONE, 8'h00},
      '{CH_SLASH, 1'b0, ROW_NONE, 8'h00},
      '{8'h62,    1'b0, ROW_NONE, 8'h00},
      '{CH_GT,    1'b0, ROW_PRED, 8'h00},
      // '>' right after '<' is a name byte
      '{CH_LT,    1'b0, ROW_NONE, 8'h00},
      '{CH_GT,    1'b0, ROW_NONE, 8'h00},
      '{CH_GT,    1'b0, ROW_NONE, 8'h00},
      // open tag at end of text, then a fresh first bold
      '{CH_LT,    1'b0, ROW_NONE, 8'h00},
      '{8'h62,    1'b1, ROW_NONE, 8'h00},
      '{CH_LT,    1'b0, ROW_NONE, 8'h00},
      '{8'h62,    1'b0, ROW_NONE, 8'h00},
      '{CH_GT,    1'b0, ROW_PRED, 8'h00}
    };

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      it.text_byte   = dir_rows[i].text_byte;
      it.end_of_text = dir_rows[i].end_of_text;
      offer(it);
      book(it, dir_rows[i].kind, dir_rows[i].want_byte);
    end

    write_color(1'b0);
    run_random(40);
    write_color(1'b1);
    long_hold_req = 1'b1;
    run_random(50);
    write_color(1'b0);
    run_random(40);
    write_color(1'b1);
    calm = 1'b1;
    run_random(50);

    in_valid <= 1'b0;
    while (due_bytes.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (n_err == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

@@ filelist.f @@
sv/hts_pkg.sv
sv/hts_front.sv
sv/hts_queue.sv
sv/hts_back.sv
sv/html_tag_stripper.sv
bench/testbench.sv
